### sv/grmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the guest region map checker.
// No dependencies; every other file of the block uses it, except grmc_cfg_if.
package grmc_pkg;

    // Table geometry and address width.
    localparam int REGION_SLOTS = 16;
    localparam int ADDR_BITS    = 32;
    localparam int SLOT_BITS    = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_BITS     = $clog2(REGION_SLOTS + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [ADDR_BITS:0]   t_sum;
    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    // Status codes of a result item.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_OVERLAP   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DENIED    = 3'd4,
        ST_BEYOND    = 3'd5
    } t_status;

    // One stored region; read and write permission are always set together.
    typedef struct packed {
        t_addr base;
        t_addr len;
        logic  perm;
    } t_tbl_entry;

    // Control from the sequencer to the region table.
    typedef struct packed {
        logic       wr_en;
        t_slot      wr_slot;
        t_tbl_entry wr_data;
        logic       rd_en;
        t_slot      rd_slot;
        logic       clr_en;
        t_slot      clr_slot;
    } t_tbl_ctrl;

endpackage

### sv/grmc_in_if.sv
`timescale 1ns / 1ps
// Command channel of the guest region map checker.
// Depends on grmc_pkg for the address width.
interface grmc_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [grmc_pkg::ADDR_BITS-1:0] guest_addr;
    logic [grmc_pkg::ADDR_BITS-1:0] length;
    logic                 allow_rw;

    modport source (output valid, output cmd, output guest_addr, output length,
                    output allow_rw, input ready);
    modport sink   (input valid, input cmd, input guest_addr, input length,
                    input allow_rw, output ready);
endinterface

### sv/grmc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the guest region map checker.
// Depends on grmc_pkg for the address width.
interface grmc_out_if;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [grmc_pkg::ADDR_BITS-1:0] host_addr;

    modport source (output valid, output status, output host_addr, input ready);
    modport sink   (input valid, input status, input host_addr, output ready);
endinterface

### sv/grmc_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel carrying the guest memory size.
// No dependencies.
interface grmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/grmc_table.sv
`timescale 1ns / 1ps
// Region table: entry memory with a registered read port and valid flags.
// Depends on grmc_pkg.
module grmc_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  grmc_pkg::t_tbl_ctrl                 i_ctrl,
    output grmc_pkg::t_tbl_entry                o_rd,
    output logic [grmc_pkg::REGION_SLOTS-1:0]   o_valid
);

    grmc_pkg::t_tbl_entry                r_mem [grmc_pkg::REGION_SLOTS];
    grmc_pkg::t_tbl_entry                r_rd;
    logic [grmc_pkg::REGION_SLOTS-1:0]   r_valid;

    // Entry storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_slot] <= i_ctrl.wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[i_ctrl.rd_slot];
        end
    end

    // Valid flags are set by an append and cleared by an unmap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctrl.clr_en) begin
                r_valid[i_ctrl.clr_slot] <= 1'b0;
            end
            if (i_ctrl.wr_en) begin
                r_valid[i_ctrl.wr_slot] <= 1'b1;
            end
        end
    end

    assign o_rd    = r_rd;
    assign o_valid = r_valid;

endmodule

### sv/guest_region_map_checker_top.sv
`timescale 1ns / 1ps
// Top level of the guest region map checker: command sequencer and result register.
// Depends on grmc_pkg, the three channel interfaces and grmc_table.

// One item is handled at a time. After acceptance the sequencer walks the
// appended slots in order, one per cycle through the registered read port of
// the region table, and stops at the first hit. A map that finds the table
// full skips the scan and goes straight to the result. The next item is taken
// the cycle after the result is taken. The guest memory size register may be
// written at any time the block holds no item and starts at zero after reset.
// Unmapped slots are never reused: once REGION_SLOTS maps have succeeded,
// every later map reports a full table.
module guest_region_map_checker_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grmc_cfg_if.sink  i_cfg,
    grmc_in_if.sink   i_cmd,
    grmc_out_if.source o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    grmc_pkg::t_cmd         r_cmd, n_cmd;
    grmc_pkg::t_addr        r_addr, n_addr;
    grmc_pkg::t_addr        r_len, n_len;
    logic                   r_rw, n_rw;
    grmc_pkg::t_sum         r_end, n_end;
    grmc_pkg::t_cnt         r_idx, n_idx;
    grmc_pkg::t_cnt         r_used, n_used;
    logic                   r_pv, n_pv;
    grmc_pkg::t_slot        r_pslot, n_pslot;
    grmc_pkg::t_status      r_status, n_status;
    grmc_pkg::t_addr        r_host, n_host;
    grmc_pkg::t_addr        r_mem_bytes;

    grmc_pkg::t_tbl_ctrl    w_ctrl;
    grmc_pkg::t_tbl_entry   w_rd;
    logic [grmc_pkg::REGION_SLOTS-1:0] w_valid;
    grmc_pkg::t_sum         w_ent_end;
    logic                   w_hit;
    logic                   w_beyond;
    logic                   w_in_acc;

    grmc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_rd    (w_rd),
        .o_valid (w_valid)
    );

    // Handshakes.
    assign i_cfg.ready   = 1'b1;
    assign i_cmd.ready   = (r_state == S_IDLE);
    assign w_in_acc      = i_cmd.valid && (r_state == S_IDLE);
    assign o_res.valid   = (r_state == S_DONE);
    assign o_res.status  = r_status;
    assign o_res.host_addr = r_host;

    // Shared compare unit: the end of the entry under test against the item.
    assign w_ent_end = {1'b0, w_rd.base} + {1'b0, w_rd.len};
    assign w_beyond  = r_end > {1'b0, r_mem_bytes};

    always_comb begin
        w_hit = 1'b0;
        if (r_pv && w_valid[r_pslot]) begin
            case (r_cmd)
                grmc_pkg::CMD_MAP: begin
                    w_hit = (w_ent_end > {1'b0, r_addr}) && (r_end > {1'b0, w_rd.base});
                end
                grmc_pkg::CMD_UNMAP: begin
                    w_hit = (w_rd.base == r_addr);
                end
                default: begin
                    w_hit = (r_addr >= w_rd.base) && ({1'b0, r_addr} < w_ent_end);
                end
            endcase
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_len    = r_len;
        n_rw     = r_rw;
        n_end    = r_end;
        n_idx    = r_idx;
        n_used   = r_used;
        n_pv     = 1'b0;
        n_pslot  = r_pslot;
        n_status = r_status;
        n_host   = r_host;

        w_ctrl          = '0;
        w_ctrl.rd_slot  = r_idx[grmc_pkg::SLOT_BITS-1:0];
        w_ctrl.wr_slot  = r_used[grmc_pkg::SLOT_BITS-1:0];
        w_ctrl.wr_data  = '{base: r_addr, len: r_len, perm: r_rw};
        w_ctrl.clr_slot = r_pslot;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd  = grmc_pkg::t_cmd'(i_cmd.cmd);
                    n_addr = i_cmd.guest_addr;
                    n_len  = i_cmd.length;
                    n_rw   = i_cmd.allow_rw;
                    n_end  = {1'b0, i_cmd.guest_addr} + {1'b0, i_cmd.length};
                    n_idx  = '0;
                    n_host = '0;
                    if ((grmc_pkg::t_cmd'(i_cmd.cmd) == grmc_pkg::CMD_MAP) &&
                        (r_used == grmc_pkg::CNT_BITS'(grmc_pkg::REGION_SLOTS))) begin
                        n_status = grmc_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    // First matching slot decides the result.
                    n_state = S_DONE;
                    n_host  = '0;
                    case (r_cmd)
                        grmc_pkg::CMD_MAP: begin
                            n_status = grmc_pkg::ST_OVERLAP;
                        end
                        grmc_pkg::CMD_UNMAP: begin
                            w_ctrl.clr_en = 1'b1;
                            n_status      = grmc_pkg::ST_OK;
                        end
                        default: begin
                            if (!w_rd.perm) begin
                                n_status = grmc_pkg::ST_DENIED;
                            end else if (w_beyond) begin
                                n_status = grmc_pkg::ST_BEYOND;
                            end else begin
                                n_status = grmc_pkg::ST_OK;
                                n_host   = r_addr;
                            end
                        end
                    endcase
                end else if (r_idx < r_used) begin
                    // Issue the read of the next appended slot.
                    w_ctrl.rd_en = 1'b1;
                    n_pv         = 1'b1;
                    n_pslot      = r_idx[grmc_pkg::SLOT_BITS-1:0];
                    n_idx        = r_idx + 1'b1;
                end else begin
                    // Every slot has been tested without a hit.
                    n_state = S_DONE;
                    n_host  = '0;
                    if (r_cmd == grmc_pkg::CMD_MAP) begin
                        w_ctrl.wr_en = 1'b1;
                        n_used       = r_used + 1'b1;
                        n_status     = grmc_pkg::ST_OK;
                    end else begin
                        n_status = grmc_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_DONE: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pv        <= 1'b0;
            r_idx       <= '0;
            r_mem_bytes <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pv    <= n_pv;
            r_idx   <= n_idx;
            if (i_cfg.valid) begin
                r_mem_bytes <= i_cfg.data;
            end
        end
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_rw     <= n_rw;
        r_end    <= n_end;
        r_pslot  <= n_pslot;
        r_status <= n_status;
        r_host   <= n_host;
    end

endmodule
